>>> sv/gb_pkg.sv
`default_nettype none
package gb_pkg;
   localparam int WIDTH_DEF = 16;
   localparam int SMALL_W   = 15;
   localparam int LARGE_W   = 16;
endpackage
`default_nettype wire

>>> sv/goldbach_min_prime_split.sv
`default_nettype none
// goldbach_min_prime_split: primality flag and smallest-prime goldbach split
// of one unsigned number per word.
// request: req_number is taken at the clock edge where start is high and
// busy is low. busy stays high until the result has been issued.
// response: rsp_valid is high for exactly one cycle with the flag, the
// found bit and the two parts; the receiver cannot hold it off, and the
// next word may be started in that same cycle.
// steps: each primality test walks divisors d = 2, 3, ... while d*d <= v,
// with the square kept by running sums. every divisor runs through a
// bit-serial restoring remainder unit (one bit of v per cycle). a word
// costs one test of the number and, for even numbers of 4 or more, a test
// of p and, when p is prime, of n - p, for each candidate p = 2, 3, ...
// until the first split or until p passes n/2.
// reset: synchronous, active high; the block returns to idle, no response.
module goldbach_min_prime_split #(
   parameter int WIDTH = gb_pkg::WIDTH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire logic [WIDTH-1:0]           req_number,
   output      logic                       rsp_valid,
   output      logic                       rsp_number_is_prime,
   output      logic                       rsp_found,
   output      logic [gb_pkg::SMALL_W-1:0] rsp_small_part,
   output      logic [gb_pkg::LARGE_W-1:0] rsp_large_part
);
   import gb_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SQ,
      ST_DIV,
      ST_CHK,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_N,
      PH_P,
      PH_Q
   } phase_type;

   state_type        state_ff;
   phase_type        phase_ff;
   logic [WIDTH-1:0] n_ff;
   logic [WIDTH-1:0] p_ff;
   logic [WIDTH-1:0] v_ff;
   logic [WIDTH-1:0] d_ff;
   logic [WIDTH:0]   sq_ff;
   logic [WIDTH:0]   rem_ff;
   logic [WIDTH-1:0] sh_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             res_ff;
   logic             isp_ff;
   logic             rsp_valid_ff;
   logic             rsp_prime_ff;
   logic             rsp_found_ff;
   logic [WIDTH-1:0] rsp_p_ff;
   logic [WIDTH-1:0] rsp_q_ff;

   logic [WIDTH:0]      rem_sh;
   logic [WIDTH:0]      rem_in;
   logic [WIDTH-1:0]    p_next;
   logic [WIDTH-1:0]    q_val;
   logic [WIDTH+15:0]   p_ext;
   logic [WIDTH+15:0]   q_ext;

   // one restoring step per cycle
   always_comb begin
      rem_sh = {rem_ff[WIDTH-1:0], sh_ff[WIDTH-1]};
      if (rem_sh >= {1'b0, d_ff}) begin
         rem_in = rem_sh - {1'b0, d_ff};
      end else begin
         rem_in = rem_sh;
      end
   end

   assign p_next = p_ff + {{(WIDTH-1){1'b0}}, 1'b1};
   assign q_val  = n_ff - p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_N;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  n_ff     <= req_number;
                  v_ff     <= req_number;
                  phase_ff <= PH_N;
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               if (v_ff < WIDTH'(2)) begin
                  res_ff   <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  d_ff     <= WIDTH'(2);
                  sq_ff    <= (WIDTH+1)'(4);
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               if (sq_ff > {1'b0, v_ff}) begin
                  res_ff   <= 1'b1;
                  state_ff <= ST_DONE;
               end else begin
                  sh_ff    <= v_ff;
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_W'(WIDTH-1);
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff <= rem_in;
               sh_ff  <= {sh_ff[WIDTH-2:0], 1'b0};
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == '0) begin
                  state_ff <= ST_CHK;
               end
            end
            ST_CHK: begin
               if (rem_ff == '0) begin
                  res_ff   <= 1'b0;
                  state_ff <= ST_DONE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  sq_ff    <= sq_ff + {d_ff, 1'b1};
                  d_ff     <= d_ff + WIDTH'(1);
                  state_ff <= ST_SQ;
               end
            end
            ST_DONE: begin
               case (phase_ff)
                  PH_N: begin
                     isp_ff <= res_ff;
                     if (n_ff >= WIDTH'(4) && !n_ff[0]) begin
                        p_ff     <= WIDTH'(2);
                        v_ff     <= WIDTH'(2);
                        phase_ff <= PH_P;
                        state_ff <= ST_START;
                     end else begin
                        rsp_valid_ff <= 1'b1;
                        rsp_prime_ff <= res_ff;
                        rsp_found_ff <= 1'b0;
                        rsp_p_ff     <= '0;
                        rsp_q_ff     <= '0;
                        state_ff     <= ST_IDLE;
                     end
                  end
                  PH_P, PH_Q: begin
                     if (res_ff && phase_ff == PH_P) begin
                        v_ff     <= q_val;
                        phase_ff <= PH_Q;
                        state_ff <= ST_START;
                     end else if (res_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_prime_ff <= isp_ff;
                        rsp_found_ff <= 1'b1;
                        rsp_p_ff     <= p_ff;
                        rsp_q_ff     <= q_val;
                        state_ff     <= ST_IDLE;
                     end else if (p_next > {1'b0, n_ff[WIDTH-1:1]}) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_prime_ff <= isp_ff;
                        rsp_found_ff <= 1'b0;
                        rsp_p_ff     <= '0;
                        rsp_q_ff     <= '0;
                        state_ff     <= ST_IDLE;
                     end else begin
                        p_ff     <= p_next;
                        v_ff     <= p_next;
                        phase_ff <= PH_P;
                        state_ff <= ST_START;
                     end
                  end
                  default: begin
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign p_ext = {16'b0, rsp_p_ff};
   assign q_ext = {16'b0, rsp_q_ff};

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_number_is_prime = rsp_prime_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_small_part      = p_ext[SMALL_W-1:0];
   assign rsp_large_part      = q_ext[LARGE_W-1:0];

endmodule
`default_nettype wire

>>> dv/tb_goldbach_min_prime_split.sv
`default_nettype none
module tb_goldbach_min_prime_split;
   import gb_pkg::*;

   localparam int WIDTH          = WIDTH_DEF;
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int TAIL_CYCLES    = 200;
   localparam int PHASE_WORDS    = 70;
   localparam int NUM_DIRECTED   = 24;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [WIDTH-1:0]   number;
      logic               is_prime;
      logic               found;
      logic [SMALL_W-1:0] small_p;
      logic [LARGE_W-1:0] large_p;
   } split_result_type;

   class gb_scoreboard;
      split_result_type split_q[$];
      int errors;
      int words;
      int checked;
      int primes;
      int splits;

      static function bit prime_test(int unsigned v);
         int unsigned d;
         if (v < 2) return 1'b0;
         for (d = 2; d * d <= v; d++)
            if (v % d == 0) return 1'b0;
         return 1'b1;
      endfunction

      function split_result_type predict_split(logic [WIDTH-1:0] n);
         split_result_type r;
         int unsigned nv;
         int unsigned p;
         nv = n;
         r.number = n;
         r.is_prime = prime_test(nv);
         r.found = 1'b0;
         r.small_p = '0;
         r.large_p = '0;
         if (nv >= 4 && nv[0] == 1'b0) begin
            for (p = 2; p <= nv / 2; p++) begin
               if (prime_test(p) && prime_test(nv - p)) begin
                  r.found = 1'b1;
                  r.small_p = p[SMALL_W-1:0];
                  r.large_p = LARGE_W'(nv - p);
                  break;
               end
            end
         end
         return r;
      endfunction

      function void note_word(logic [WIDTH-1:0] n);
         split_result_type r;
         r = predict_split(n);
         split_q.push_back(r);
         words++;
         if (r.is_prime) primes++;
         if (r.found) splits++;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("%t: %s", $time, msg);
      endfunction

      function void check_result(logic is_prime, logic found,
                                 logic [SMALL_W-1:0] small_p,
                                 logic [LARGE_W-1:0] large_p);
         split_result_type e;
         if (split_q.size() == 0) begin
            flag($sformatf("unexpected result prime=%b found=%b p=%0d q=%0d",
                           is_prime, found, small_p, large_p));
            return;
         end
         e = split_q.pop_front();
         checked++;
         if (is_prime !== e.is_prime || found !== e.found ||
             small_p !== e.small_p || large_p !== e.large_p)
            flag($sformatf({"mismatch n=%0d: exp prime=%b found=%b p=%0d q=%0d",
                            " got prime=%b found=%b p=%0d q=%0d"},
                           e.number, e.is_prime, e.found, e.small_p, e.large_p,
                           is_prime, found, small_p, large_p));
      endfunction

      function int pending();
         return split_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [WIDTH-1:0]   req_number = '0;
   logic               busy;
   logic               rsp_valid;
   logic               rsp_number_is_prime;
   logic               rsp_found;
   logic [SMALL_W-1:0] rsp_small_part;
   logic [LARGE_W-1:0] rsp_large_part;

   gb_scoreboard sb = new();
   int idle_cycles = 0;

   goldbach_min_prime_split #(.WIDTH(WIDTH)) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_number          (req_number),
      .rsp_valid           (rsp_valid),
      .rsp_number_is_prime (rsp_number_is_prime),
      .rsp_found           (rsp_found),
      .rsp_small_part      (rsp_small_part),
      .rsp_large_part      (rsp_large_part)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_number_is_prime, rsp_found, rsp_small_part,
                            rsp_large_part);
         if (start && !busy)
            sb.note_word(req_number);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word accepted for %0d cycles", idle_cycles);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_word(input logic [WIDTH-1:0] n);
      req_number <= n;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic sender_gap(input int pct);
      int gap;
      if (pct > 0 && $urandom_range(99) < pct) begin
         gap = ($urandom_range(3) == 0) ? $urandom_range(1, 1500) : $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      // let the last accepted word reach the scoreboard first
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // mostly small even numbers, a few across the full range
   function automatic logic [WIDTH-1:0] pick_number();
      int sel;
      logic [WIDTH-1:0] n;
      sel = $urandom_range(99);
      if (sel < 6) n = WIDTH'($urandom_range(65535));
      else if (sel < 25) n = WIDTH'($urandom_range(8191));
      else n = WIDTH'($urandom_range(1023));
      if ($urandom_range(99) < 75) n[0] = 1'b0;
      return n;
   endfunction

   initial begin
      int unsigned directed_words[NUM_DIRECTED];
      int idle_pct[4];
      int ph;
      int i;

      directed_words = '{
         0, 1, 2, 3, 4, 5, 6, 8, 9, 12, 15, 25, 49, 97, 98, 121, 128, 1024,
         65521, 65535, 65534, 65532, 21846, 43690};
      idle_pct = '{0, 70, 0, 34};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_words[k])
         send_word(WIDTH'(directed_words[k]));
      wait_all_results();

      for (ph = 0; ph < 4; ph++) begin
         for (i = 0; i < PHASE_WORDS; i++) begin
            sender_gap(idle_pct[ph]);
            send_word(pick_number());
         end
         // hold off until the block has answered everything
         wait_all_results();
      end

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d words (directed edge values, then four idle phases)", sb.words);
      $display("%0d prime, %0d with a prime split, %0d results checked",
               sb.primes, sb.splits, sb.checked);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
sv/gb_pkg.sv
sv/goldbach_min_prime_split.sv
dv/tb_goldbach_min_prime_split.sv
